/* hdl/signed_decimal_ascii_formatter_macros.svh */
// Assertion macros used by the formatter checker.
// Needs a clk and an rst signal in the scope where the macros are used.
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_MACROS_SVH

// Checked only outside reset.
`define SDAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SDAF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/sdaf_pkg.sv */
// Shared types and constants for the signed decimal ASCII formatter.
// No dependencies.
package sdaf_pkg;

  localparam int BCD_DIGITS = 10;  // digits of the largest 32-bit magnitude
  localparam int VALUE_W    = 32;
  localparam int STEPS      = 32;  // one shift-add-3 step per magnitude bit
  localparam int STEP_W     = 5;
  localparam int CNT_W      = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // output byte selection
  localparam logic [1:0] SEL_MINUS = 2'd0;
  localparam logic [1:0] SEL_DIGIT = 2'd1;
  localparam logic [1:0] SEL_EOL   = 2'd2;

  typedef struct packed {
    logic       load;   // capture input value, clear digits
    logic       step;   // one shift-add-3 step
    logic       size;   // find digit count, point at top digit
    logic       emit;   // load output register
    logic [1:0] sel;    // byte to emit
  } cmd_t;

  typedef struct packed {
    logic negative;
    logic last_digit;
    logic out_free;
  } stat_t;

  function automatic logic [VALUE_W-1:0] pow10(input int n);
    logic [VALUE_W-1:0] p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = VALUE_W'(p * 10);
    end
    return p;
  endfunction

endpackage

/* hdl/sdaf_datapath.sv */
// Datapath: magnitude, shift-add-3 binary to BCD converter, digit pointer
// and output byte register. Depends on sdaf_pkg.
module sdaf_datapath import sdaf_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [VALUE_W-1:0] value,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_char,
  output logic                      out_last
);

  localparam int KEEP  = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
  localparam int IDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;
  localparam logic [VALUE_W-1:0] TOP_POW = pow10(KEEP - 1);

  logic [VALUE_W-1:0] magnitude;
  logic [VALUE_W-1:0] shreg;
  logic [KEEP*4-1:0]  digit_store;
  logic [KEEP*4-1:0]  adj;
  logic               negative_flag;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   digit_count;
  logic [VALUE_W-1:0] mag_in;
  logic [3:0]         cur_digit;
  logic [7:0]         char_sel;

  assign mag_in = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = digit_store;
    for (int i = 0; i < KEEP; i++) begin
      if (digit_store[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digit_store[4*i +: 4] + 4'd3;
      end
    end
  end

  // digits printed: up to the top nonzero one, at least one, all kept
  // digits once the value reaches 10^(KEEP-1)
  always_comb begin
    digit_count = CNT_W'(1);
    for (int i = 0; i < KEEP; i++) begin
      if (digit_store[4*i +: 4] != 4'd0) begin
        digit_count = CNT_W'(i + 1);
      end
    end
    if (magnitude >= TOP_POW) begin
      digit_count = CNT_W'(KEEP);
    end
  end

  assign cur_digit = digit_store[{idx, 2'b00} +: 4];

  always_comb begin
    case (cmd.sel)
      SEL_MINUS: char_sel = CHAR_MINUS;
      SEL_DIGIT: char_sel = CHAR_ZERO + {4'd0, cur_digit};
      SEL_EOL:   char_sel = CHAR_LF;
      default:   char_sel = CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude     <= '0;
      negative_flag <= 1'b0;
      idx           <= '0;
    end else begin
      if (cmd.load) begin
        magnitude     <= mag_in;
        negative_flag <= value[VALUE_W-1];
      end
      if (cmd.size) begin
        idx <= IDX_W'(digit_count - CNT_W'(1));
      end else if (cmd.emit && cmd.sel == SEL_DIGIT && idx != '0) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  // converter registers: written by load before any read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg       <= mag_in;
      digit_store <= '0;
    end else if (cmd.step) begin
      shreg       <= {shreg[VALUE_W-2:0], 1'b0};
      digit_store <= {adj[KEEP*4-2:0], shreg[VALUE_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= char_sel;
      out_last <= (cmd.sel == SEL_EOL);
    end
  end

  assign stat.negative   = negative_flag;
  assign stat.last_digit = (idx == '0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

/* hdl/sdaf_controller.sv */
// Sequencer for the formatter: conversion steps, then sign, digits and
// line feed. Depends on sdaf_pkg.
module sdaf_controller import sdaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SIZE  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;
  localparam logic [2:0] S_EOL   = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] iter;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_EOL;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (iter == STEP_W'(STEPS - 1)) begin
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = stat.negative ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        cmd.sel = SEL_MINUS;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.sel = SEL_DIGIT;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_digit) begin
            state_next = S_EOL;
          end
        end
      end
      S_EOL: begin
        cmd.sel = SEL_EOL;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (state == S_CONV) begin
        iter <= iter + STEP_W'(1);
      end else begin
        iter <= '0;
      end
    end
  end

endmodule

/* hdl/signed_decimal_ascii_formatter.sv */
// Signed decimal ASCII formatter: each 32-bit signed request comes out as
// its decimal text, an optional '-', the digits most significant first and a
// closing line feed flagged by tlast. A request is accepted, then converted
// by a 32-step shift-add-3 loop (one step per magnitude bit), then the size
// state sets the digit count, then one byte leaves per cycle while the output
// is taken. The next request is taken while the line feed still waits in the
// output register. MAX_DIGITS (1..20) keeps only that many low digits, at
// most 10. Depends on sdaf_pkg.
module signed_decimal_ascii_formatter import sdaf_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast    // last
);

  cmd_t  cmd;
  stat_t stat;

  sdaf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdaf_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     ($signed(s_axis_tdata)),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

/* hdl/sdaf_checker.sv */
// Port-level checker for the formatter, bound to the top level.
// Depends on sdaf_pkg and the assertion macro header.
`include "signed_decimal_ascii_formatter_macros.svh"

module sdaf_checker import sdaf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  `SDAF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped while stalled")
  `SDAF_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
  `SDAF_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken during conversion")
  `SDAF_ASSERT(a_last_is_lf, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CHAR_LF, "last byte is not a line feed")
  `SDAF_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (.*);
